FILE: hdl/insertion_sorter_unit_macros.svh
// ----------------------------------------------------------------------------
// insertion_sorter_unit_macros.svh
// Assertion macros used by the sorter RTL. Every macro expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_UNIT_MACROS_SVH
`define INSERTION_SORTER_UNIT_MACROS_SVH

// cond must never hold outside reset
`define ISU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// same-cycle implication
`define ISU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Types shared by the sorter cell and the sorter top level.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast key
    logic drn;  // shift the whole chain down one place
  } cell_ctrl_t;

endpackage

FILE: hdl/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell
// One slot of the sorted chain: holds a value and an occupied flag. On an
// insert it takes its lower neighbor's entry, the key, or keeps its own; on
// a drain it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module iss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  iss_pkg::cell_ctrl_t ctrl,
  input  iss_pkg::word_t     key,
  input  iss_pkg::word_t     lo_val,
  input  logic               lo_occ,
  input  logic               lo_gt,
  input  iss_pkg::word_t     hi_val,
  input  logic               hi_occ,
  output iss_pkg::word_t     val,
  output logic               occ,
  output logic               gt
);
  import iss_pkg::*;

  word_t val_r, val_nxt;
  logic  occ_r, occ_nxt;

  // An empty slot counts as greater than any key
  assign gt = !occ_r || (val_r > key);

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctrl.ins) begin
      if (lo_gt) begin
        val_nxt = lo_val;
        occ_nxt = lo_occ;
      end else if (gt) begin
        val_nxt = key;
        occ_nxt = 1'b1;
      end
    end else if (ctrl.drn) begin
      val_nxt = hi_val;
      occ_nxt = hi_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign occ = occ_r;

endmodule

FILE: hdl/insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable insertion sorter built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Input beats are taken one per cycle while a list is being collected; each
// value is compared against all CAPACITY cells at once and the larger
// entries move up one cell in that same cycle. Once the beat flagged is_last
// is taken, the chain drains
// from cell 0 one result beat per cycle (stalls from out_ready extend it),
// and no input is taken until the last result (end_of_list) is delivered.
// Values arriving with the chain full are dropped and every result of that
// list carries overflow.
// ----------------------------------------------------------------------------
module insertion_sorter_unit #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  iss_pkg::word_t in_value,
  input  logic           in_is_last,
  output logic           out_valid,
  input  logic           out_ready,
  output iss_pkg::word_t out_sorted_value,
  output logic           out_end_of_list,
  output logic           out_overflow
);
  import iss_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_acc, out_acc, full;
  cell_ctrl_t       ctrl;

  word_t            cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] cell_gt;

  assign full     = (fill_r == CNT_W'(CAPACITY));
  assign in_ready = (state_r == ST_FILL);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  assign ctrl.ins = in_acc && !full;
  assign ctrl.drn = out_acc;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      word_t lo_val, hi_val;
      logic  lo_occ, lo_gt, hi_occ;
      if (g == 0) begin : g_bot
        assign lo_val = '0;
        assign lo_occ = 1'b0;
        assign lo_gt  = 1'b0;
      end else begin : g_mid_lo
        assign lo_val = cell_val[g-1];
        assign lo_occ = cell_occ[g-1];
        assign lo_gt  = cell_gt[g-1];
      end
      if (g == CAPACITY - 1) begin : g_top
        assign hi_val = '0;
        assign hi_occ = 1'b0;
      end else begin : g_mid_hi
        assign hi_val = cell_val[g+1];
        assign hi_occ = cell_occ[g+1];
      end
      iss_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .key    (in_value),
        .lo_val (lo_val),
        .lo_occ (lo_occ),
        .lo_gt  (lo_gt),
        .hi_val (hi_val),
        .hi_occ (hi_occ),
        .val    (cell_val[g]),
        .occ    (cell_occ[g]),
        .gt     (cell_gt[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    remain_nxt = remain_r;
    ovf_nxt    = ovf_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (in_is_last) begin
            // list never empty: either this beat was stored or chain is full
            remain_nxt = full ? fill_r : fill_r + CNT_W'(1);
            fill_nxt   = '0;
            state_nxt  = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          remain_nxt = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            ovf_nxt   = 1'b0;
            state_nxt = ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_FILL;
      fill_r   <= '0;
      remain_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      remain_r <= remain_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_sorted_value = cell_val[0];
  assign out_end_of_list  = (remain_r == CNT_W'(1));
  assign out_overflow     = ovf_r;

`include "insertion_sorter_unit_macros.svh"

  `ISU_ASSERT_IMPL(a_head_occupied, out_valid, cell_occ[0], "result beat from empty cell")
  `ISU_ASSERT_IMPL(a_fill_matches, state_r == ST_FILL, $countones(cell_occ) == fill_r, "fill count mismatch")
  `ISU_ASSERT_IMPL(a_remain_matches, state_r == ST_DRAIN, $countones(cell_occ) == remain_r, "drain count mismatch")
  `ISU_ASSERT_NEXT(a_empty_after_list, out_acc && out_end_of_list, cell_occ == '0, "chain not empty after list")
  `ISU_ASSERT_NEVER(a_one_side, in_ready && out_valid, "input and output open together")

endmodule

FILE: tb/insertion_sorter_checker.sv
// ----------------------------------------------------------------------------
// insertion_sorter_checker
// Watches both channels of the sorter, keeps its own sorted copy of the
// list being collected and checks every result beat against it in order.
// ----------------------------------------------------------------------------
module insertion_sorter_checker #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  iss_pkg::word_t in_value,
  input  logic           in_is_last,
  input  logic           out_valid,
  input  logic           out_ready,
  input  iss_pkg::word_t out_sorted_value,
  input  logic           out_end_of_list,
  input  logic           out_overflow,
  output int unsigned    error_count,
  output int unsigned    pending
);
  import iss_pkg::*;

  typedef struct packed {
    word_t key;
    logic  eol;
    logic  ovf;
  } sorted_beat_t;

  word_t        sorted_keys [CAPACITY];
  int unsigned  key_count;
  bit           keys_dropped;
  sorted_beat_t sorted_beats_due [$];
  int unsigned  mismatch_total;

  // stable insert: only strictly greater keys move up
  function automatic void insert_key(word_t key);
    int unsigned pos;
    if (key_count >= CAPACITY) begin
      keys_dropped = 1'b1;
      return;
    end
    pos = key_count;
    while (pos > 0 && sorted_keys[pos-1] > key) begin
      sorted_keys[pos] = sorted_keys[pos-1];
      pos--;
    end
    sorted_keys[pos] = key;
    key_count++;
  endfunction

  function automatic void release_sorted_list();
    sorted_beat_t b;
    for (int unsigned k = 0; k < key_count; k++) begin
      b.key = sorted_keys[k];
      b.eol = (k + 1 == key_count);
      b.ovf = keys_dropped;
      sorted_beats_due.push_back(b);
    end
    key_count    = 0;
    keys_dropped = 1'b0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_total++;
    if (mismatch_total <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : watch
    sorted_beat_t got;
    sorted_beat_t want;
    if (!rst_n) begin
      sorted_beats_due.delete();
      key_count    = 0;
      keys_dropped = 1'b0;
    end else begin
      // result side first so a same-edge last beat can't feed this compare
      if (out_valid && out_ready) begin
        got.key = out_sorted_value;
        got.eol = out_end_of_list;
        got.ovf = out_overflow;
        if (sorted_beats_due.size() == 0) begin
          note_mismatch($sformatf("unexpected beat: value %0d eol %0b ovf %0b",
                                  got.key, got.eol, got.ovf));
        end else begin
          want = sorted_beats_due.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "expected value %0d eol %0b ovf %0b, got value %0d eol %0b ovf %0b",
              want.key, want.eol, want.ovf, got.key, got.eol, got.ovf));
        end
      end
      if (in_valid && in_ready) begin
        insert_key(in_value);
        if (in_is_last) release_sorted_list();
      end
    end
    pending     <= sorted_beats_due.size();
    error_count <= mismatch_total;
  end

endmodule

FILE: tb/tb_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// tb_insertion_sorter_unit
// Feeds lists to the insertion sorter: directed edge lists, lists at and past
// capacity, then random lists, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_insertion_sorter_unit;
  import iss_pkg::*;

  localparam int          CAPACITY       = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 230;
  localparam word_t       KEY_MIN        = 32'sh8000_0000;
  localparam word_t       KEY_MAX        = 32'sh7fff_ffff;

  logic  clk        = 1'b0;
  logic  rst_n      = 1'b0;
  logic  in_valid   = 1'b0;
  logic  in_ready;
  word_t in_value   = '0;
  logic  in_is_last = 1'b0;
  logic  out_valid;
  logic  out_ready  = 1'b0;
  word_t out_sorted_value;
  logic  out_end_of_list;
  logic  out_overflow;

  int unsigned error_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned fed          = 0;     // input beats taken so far
  bit          calm         = 1'b0;  // no idling on either side while set
  word_t       list_buf [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  insertion_sorter_unit #(.CAPACITY(CAPACITY)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_list  (out_end_of_list),
    .out_overflow     (out_overflow)
  );

  insertion_sorter_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_list  (out_end_of_list),
    .out_overflow     (out_overflow),
    .error_count      (error_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mix of full-range words, extremes and a narrow band that forces equal keys
  function automatic word_t pick_key();
    case ($urandom_range(7))
      0, 1: pick_key = word_t'($urandom_range(6)) - 3;
      2: begin
        case ($urandom_range(3))
          0: pick_key = KEY_MIN;
          1: pick_key = KEY_MAX;
          2: pick_key = '0;
          default: pick_key = -1;
        endcase
      end
      default: pick_key = word_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(input word_t key, input logic last);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= key;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    fed++;
  endtask

  task automatic send_list_buf();
    for (int i = 0; i < list_buf.size(); i++)
      send_beat(list_buf[i], i == list_buf.size() - 1);
  endtask

  task automatic send_random_list(input int unsigned len);
    list_buf.delete();
    repeat (len) list_buf.push_back(pick_key());
    send_list_buf();
  endtask

  initial begin
    int unsigned list_no;
    int unsigned len;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single-entry lists at both extremes, duplicates, sorted and reversed input
    list_buf = '{KEY_MAX};
    send_list_buf();
    list_buf = '{KEY_MIN};
    send_list_buf();
    list_buf = '{3, -1, 3, 0, KEY_MIN, KEY_MAX, -1, 3};
    send_list_buf();
    list_buf = '{0, -1, 1};
    send_list_buf();
    list_buf = '{KEY_MAX, 1, 0, -1, KEY_MIN};
    send_list_buf();
    list_buf = '{KEY_MIN, -1, 0, 1, KEY_MAX};
    send_list_buf();

    // exactly full, then overfull with the last beat itself dropped
    send_random_list(CAPACITY);
    send_random_list(CAPACITY + 3);

    list_no = 0;
    while (fed < RANDOM_ITEMS) begin
      calm = (list_no >= 4 && list_no < 9);
      if ($urandom_range(14) == 0) len = $urandom_range(CAPACITY + 6, CAPACITY - 4);
      else len = $urandom_range(12, 1);
      send_random_list(len);
      list_no++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
